@@ design/audio_format_tick_scheduler_defines.svh @@
// Assertion macros shared by the checker of the audio format tick scheduler.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef AUDIO_FORMAT_TICK_SCHEDULER_DEFINES_SVH
`define AUDIO_FORMAT_TICK_SCHEDULER_DEFINES_SVH

// A property that must hold in the same cycle whenever its condition holds.
`define AFT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// A property that must hold in the cycle after its condition holds.
`define AFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/aft_pkg.sv @@
// Package of the audio format tick scheduler: widths, codes and the state type.
// Used by every module of the block; depends on nothing.
package aft_pkg;

    localparam int NUM_SLOTS       = 8;
    localparam int SLOT_W          = 3;
    localparam int MAX_SUBSCRIBERS = 255;
    localparam int COUNT_W         = 8;
    localparam int RATE_W          = 20;
    localparam int CHAN_W          = 8;
    localparam int BITS_W          = 8;
    localparam int PERIOD_W        = 46;
    localparam int TIME_W          = 64;
    localparam int CHUNK_W         = 16;
    localparam int TICKR_W         = 30;
    localparam int BPS_A_W         = 13;
    localparam int BPS_W           = 33;
    localparam int DIV_CNT_W       = 6;

    // Operation codes of an input item.
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // Kinds of result items.
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_UNREG = 2'd1;
    localparam logic [1:0] KIND_FIRE  = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RATE  = 3'd1;
    localparam logic [2:0] ST_BAD_CHAN  = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_SATURATED = 3'd6;

    // Configuration register indexes.
    localparam logic REG_CHUNK_BYTES = 1'b0;
    localparam logic REG_TICK_RATE   = 1'b1;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd1152;
    localparam logic [TICKR_W-1:0] TICKR_RESET = 30'd1000000000;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_REG_SCAN  = 10'b0000000010,
        S_MUL_A     = 10'b0000000100,
        S_MUL_B     = 10'b0000001000,
        S_DIV_GO    = 10'b0000010000,
        S_DIV       = 10'b0000100000,
        S_ALLOC     = 10'b0001000000,
        S_TICK_SCAN = 10'b0010000000,
        S_CATCHUP   = 10'b0100000000,
        S_FLUSH     = 10'b1000000000
    } seq_state_t;

endpackage

@@ design/aft_cfg.sv @@
// Configuration registers of the audio format tick scheduler behind an APB-style port.
// Depends on aft_pkg.
module aft_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [aft_pkg::CHUNK_W-1:0]   chunk_bytes,
    output logic [aft_pkg::TICKR_W-1:0]   tick_rate
);

    logic [aft_pkg::CHUNK_W-1:0] chunk_reg;
    logic [aft_pkg::TICKR_W-1:0] tickr_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= aft_pkg::CHUNK_RESET;
            tickr_reg <= aft_pkg::TICKR_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == aft_pkg::REG_CHUNK_BYTES)
            begin
                chunk_reg <= pwdata[aft_pkg::CHUNK_W-1:0];
            end
            else
            begin
                tickr_reg <= pwdata[aft_pkg::TICKR_W-1:0];
            end
        end
    end

    // Read data follows the address.
    always_comb
    begin
        if (paddr[2] == aft_pkg::REG_CHUNK_BYTES)
        begin
            prdata = {16'd0, chunk_reg};
        end
        else
        begin
            prdata = {2'd0, tickr_reg};
        end
    end

    assign chunk_bytes = chunk_reg;
    assign tick_rate   = tickr_reg;

endmodule

@@ design/aft_div.sv @@
// Restoring divider, one quotient bit per cycle, for the period computation.
// Depends on aft_pkg.
module aft_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [aft_pkg::PERIOD_W-1:0]   dividend,
    input  logic [aft_pkg::BPS_W-1:0]      divisor,
    output logic                           done,
    output logic [aft_pkg::PERIOD_W-1:0]   quotient
);

    logic [aft_pkg::BPS_W-1:0]     rem_reg;
    logic [aft_pkg::BPS_W-1:0]     rem_next;
    logic [aft_pkg::PERIOD_W-1:0]  quo_reg;
    logic [aft_pkg::PERIOD_W-1:0]  quo_next;
    logic [aft_pkg::BPS_W-1:0]     dvs_reg;
    logic [aft_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [aft_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          run_reg;
    logic                          run_next;
    logic                          done_next;
    logic [aft_pkg::BPS_W:0]       shifted;
    logic [aft_pkg::BPS_W:0]       diff;

    // One shift-subtract step per cycle.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[aft_pkg::PERIOD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (run_reg)
        begin
            if (!diff[aft_pkg::BPS_W])
            begin
                rem_next = diff[aft_pkg::BPS_W-1:0];
                quo_next = {quo_reg[aft_pkg::PERIOD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[aft_pkg::BPS_W-1:0];
                quo_next = {quo_reg[aft_pkg::PERIOD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == aft_pkg::DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= done_next;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= aft_pkg::DIV_CNT_W'(aft_pkg::PERIOD_W);
            end
            else
            begin
                run_reg <= run_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

@@ design/audio_format_tick_scheduler.sv @@
// Top level of the audio format tick scheduler: sequencer, slot table and output register.
// Depends on aft_pkg, aft_cfg and aft_div.
//
// Usage: an item (operation and its fields) is accepted at a rising edge with start high
// and busy low. Results appear on kind, status, slot_index, subscribers, period_ticks and
// last for one cycle each, marked by result_valid; the receiver cannot stall, so every
// result is taken in that cycle. last marks the final result of an item.
// Errors and unregister items finish in the accept cycle and their result shows in the
// next cycle; ignored operations give no result; busy stays low for all of these. A
// register item scans the slots one per cycle and stops at a matching slot; if none
// matches, it reports the table full or opens a new slot through the multiply states
// S_MUL_A and S_MUL_B, a divider start, the divider run and a table write. A tick scans
// the slots one per cycle through the shared 64-bit adder, but a slot whose deadline is
// not yet past now after one period adds catch-up steps; a flush step ends the tick.
// Each result shows in the cycle after the one that produced it.
// Reset: all slots free, time zero, configuration at its reset values. The slot table
// needs no clearing pass; the block accepts items right after reset. The user must
// write configuration via the APB-style port only while idle; the block does not check.
module audio_format_tick_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [aft_pkg::RATE_W-1:0]     frame_rate,
    input  logic [aft_pkg::CHAN_W-1:0]     channel_count,
    input  logic [aft_pkg::BITS_W-1:0]     sample_bits,
    input  logic [aft_pkg::SLOT_W-1:0]     slot,
    output logic                           result_valid,
    output logic [1:0]                     kind,
    output logic [2:0]                     status,
    output logic [aft_pkg::SLOT_W-1:0]     slot_index,
    output logic [aft_pkg::COUNT_W-1:0]    subscribers,
    output logic [aft_pkg::PERIOD_W-1:0]   period_ticks,
    output logic                           last
);

    localparam int SW = aft_pkg::SLOT_W;
    localparam int PW = aft_pkg::PERIOD_W;
    localparam int TW = aft_pkg::TIME_W;
    localparam int CW = aft_pkg::COUNT_W;

    logic [aft_pkg::CHUNK_W-1:0] chunk_bytes;
    logic [aft_pkg::TICKR_W-1:0] tick_rate;

    aft_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .chunk_bytes (chunk_bytes),
        .tick_rate   (tick_rate)
    );

    // Slot table.
    logic [aft_pkg::NUM_SLOTS-1:0]  used_reg;
    logic [CW-1:0]                  count_reg [aft_pkg::NUM_SLOTS];
    logic [aft_pkg::RATE_W-1:0]     rate_tbl  [aft_pkg::NUM_SLOTS];
    logic [aft_pkg::CHAN_W-1:0]     chan_tbl  [aft_pkg::NUM_SLOTS];
    logic [aft_pkg::BITS_W-1:0]     bits_tbl  [aft_pkg::NUM_SLOTS];
    logic [PW-1:0]                  per_tbl   [aft_pkg::NUM_SLOTS];
    logic [TW-1:0]                  dl_tbl    [aft_pkg::NUM_SLOTS];

    // Sequencer state.
    aft_pkg::seq_state_t state_reg, state_next;
    logic [TW-1:0]                  now_reg, now_next;
    logic [SW-1:0]                  idx_reg, idx_next;
    logic [SW-1:0]                  free_reg, free_next;
    logic                           free_ok_reg, free_ok_next;
    logic [aft_pkg::RATE_W-1:0]     rate_reg;
    logic [aft_pkg::CHAN_W-1:0]     chan_reg;
    logic [aft_pkg::BITS_W-1:0]     bits_reg;
    logic [aft_pkg::BPS_A_W-1:0]    prod_a_reg;
    logic [aft_pkg::BPS_W-1:0]      bps_reg;
    logic [PW-1:0]                  num_reg;

    // Pending fired result, held until it is known whether it is the last.
    logic                           pend_reg, pend_next;
    logic [SW-1:0]                  pslot_reg, pslot_next;
    logic [CW-1:0]                  psubs_reg, psubs_next;
    logic [PW-1:0]                  pper_reg, pper_next;

    // Output register.
    logic                           rv_next;
    logic [1:0]                     kind_next;
    logic [2:0]                     status_next;
    logic [SW-1:0]                  sidx_next;
    logic [CW-1:0]                  subs_next;
    logic [PW-1:0]                  per_next;
    logic                           last_next;

    // Table write controls.
    logic                           alloc_we;
    logic                           dl_we;
    logic                           cnt_we;
    logic                           used_clr;
    logic [SW-1:0]                  wr_idx;
    logic [CW-1:0]                  cnt_wdata;

    // Read port and shared adder.
    logic [SW-1:0]                  rd_idx;
    logic                           rd_used;
    logic [CW-1:0]                  rd_count;
    logic [PW-1:0]                  rd_per;
    logic [TW-1:0]                  rd_dl;
    logic                           rd_match;
    logic [TW-1:0]                  add_a;
    logic [TW-1:0]                  add_b;
    logic [TW-1:0]                  sum;
    logic                           sum_past;
    logic [PW-1:0]                  new_per;
    logic                           last_slot;

    logic                           div_start;
    logic                           div_done;
    logic [PW-1:0]                  div_q;

    aft_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (bps_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy      = (state_reg != aft_pkg::S_IDLE);
    assign div_start = (state_reg == aft_pkg::S_DIV_GO);
    assign last_slot = (idx_reg == SW'(aft_pkg::NUM_SLOTS - 1));

    // Single read port of the table.
    assign rd_idx   = (state_reg == aft_pkg::S_IDLE) ? slot : idx_reg;
    assign rd_used  = used_reg[rd_idx];
    assign rd_count = count_reg[rd_idx];
    assign rd_per   = per_tbl[rd_idx];
    assign rd_dl    = dl_tbl[rd_idx];
    assign rd_match = rd_used && (rate_tbl[rd_idx] == rate_reg)
                      && (chan_tbl[rd_idx] == chan_reg) && (bits_tbl[rd_idx] == bits_reg);

    // A quotient of zero or one gives a period of one.
    assign new_per = (div_q <= PW'(1)) ? PW'(1) : div_q;

    // Shared 64-bit adder: deadline plus period, or time plus new period.
    always_comb
    begin
        if (state_reg == aft_pkg::S_ALLOC)
        begin
            add_a = now_reg;
            add_b = {{(TW-PW){1'b0}}, new_per};
        end
        else
        begin
            add_a = rd_dl;
            add_b = {{(TW-PW){1'b0}}, rd_per};
        end
    end
    assign sum      = add_a + add_b;
    assign sum_past = (sum > now_reg);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        pend_next    = pend_reg;
        pslot_next   = pslot_reg;
        psubs_next   = psubs_reg;
        pper_next    = pper_reg;
        rv_next      = 1'b0;
        kind_next    = kind;
        status_next  = status;
        sidx_next    = slot_index;
        subs_next    = subscribers;
        per_next     = period_ticks;
        last_next    = last;
        alloc_we     = 1'b0;
        dl_we        = 1'b0;
        cnt_we       = 1'b0;
        used_clr     = 1'b0;
        wr_idx       = idx_reg;
        cnt_wdata    = rd_count;

        case (state_reg)
            aft_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        aft_pkg::OP_REGISTER:
                        begin
                            // Validate the format before scanning.
                            kind_next   = aft_pkg::KIND_REG;
                            sidx_next   = '0;
                            subs_next   = '0;
                            per_next    = '0;
                            last_next   = 1'b1;
                            if (frame_rate == '0)
                            begin
                                rv_next     = 1'b1;
                                status_next = aft_pkg::ST_BAD_RATE;
                            end
                            else if (channel_count == '0)
                            begin
                                rv_next     = 1'b1;
                                status_next = aft_pkg::ST_BAD_CHAN;
                            end
                            else if (sample_bits == '0 || sample_bits[2:0] != 3'd0)
                            begin
                                rv_next     = 1'b1;
                                status_next = aft_pkg::ST_BAD_DEPTH;
                            end
                            else
                            begin
                                idx_next     = '0;
                                free_ok_next = 1'b0;
                                state_next   = aft_pkg::S_REG_SCAN;
                            end
                        end
                        aft_pkg::OP_UNREGISTER:
                        begin
                            rv_next   = 1'b1;
                            kind_next = aft_pkg::KIND_UNREG;
                            sidx_next = slot;
                            last_next = 1'b1;
                            wr_idx    = slot;
                            if (!rd_used)
                            begin
                                status_next = aft_pkg::ST_EMPTY;
                                subs_next   = '0;
                                per_next    = '0;
                            end
                            else
                            begin
                                cnt_wdata   = (rd_count != '0) ? rd_count - 1'b1 : rd_count;
                                cnt_we      = 1'b1;
                                used_clr    = (cnt_wdata == '0);
                                status_next = aft_pkg::ST_OK;
                                subs_next   = cnt_wdata;
                                per_next    = rd_per;
                            end
                        end
                        aft_pkg::OP_TICK:
                        begin
                            now_next   = now_reg + TW'(1);
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = aft_pkg::S_TICK_SCAN;
                        end
                        default:
                        begin
                            state_next = aft_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            aft_pkg::S_REG_SCAN:
            begin
                kind_next = aft_pkg::KIND_REG;
                last_next = 1'b1;
                if (rd_match)
                begin
                    // Join the slot that already has this format, or report it saturated.
                    rv_next    = 1'b1;
                    sidx_next  = idx_reg;
                    state_next = aft_pkg::S_IDLE;
                    if (32'(rd_count) >= aft_pkg::MAX_SUBSCRIBERS)
                    begin
                        status_next = aft_pkg::ST_SATURATED;
                        subs_next   = rd_count;
                        per_next    = '0;
                    end
                    else
                    begin
                        cnt_wdata   = rd_count + 1'b1;
                        cnt_we      = 1'b1;
                        status_next = aft_pkg::ST_OK;
                        subs_next   = cnt_wdata;
                        per_next    = rd_per;
                    end
                end
                else
                begin
                    if (!rd_used && !free_ok_reg)
                    begin
                        free_next    = idx_reg;
                        free_ok_next = 1'b1;
                    end
                    if (last_slot)
                    begin
                        if (!free_ok_next)
                        begin
                            rv_next     = 1'b1;
                            status_next = aft_pkg::ST_FULL;
                            sidx_next   = '0;
                            subs_next   = '0;
                            per_next    = '0;
                            state_next  = aft_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = aft_pkg::S_MUL_A;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            aft_pkg::S_MUL_A:
            begin
                state_next = aft_pkg::S_MUL_B;
            end

            aft_pkg::S_MUL_B:
            begin
                state_next = aft_pkg::S_DIV_GO;
            end

            aft_pkg::S_DIV_GO:
            begin
                state_next = aft_pkg::S_DIV;
            end

            aft_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = aft_pkg::S_ALLOC;
                end
            end

            aft_pkg::S_ALLOC:
            begin
                // Open the new slot with its first deadline.
                wr_idx      = free_reg;
                alloc_we    = 1'b1;
                rv_next     = 1'b1;
                kind_next   = aft_pkg::KIND_REG;
                status_next = aft_pkg::ST_OK;
                sidx_next   = free_reg;
                subs_next   = CW'(1);
                per_next    = new_per;
                last_next   = 1'b1;
                state_next  = aft_pkg::S_IDLE;
            end

            aft_pkg::S_TICK_SCAN:
            begin
                if (rd_used && (rd_dl <= now_reg))
                begin
                    // Release the previous fired slot, hold this one.
                    if (pend_reg)
                    begin
                        rv_next     = 1'b1;
                        kind_next   = aft_pkg::KIND_FIRE;
                        status_next = aft_pkg::ST_OK;
                        sidx_next   = pslot_reg;
                        subs_next   = psubs_reg;
                        per_next    = pper_reg;
                        last_next   = 1'b0;
                    end
                    pend_next  = 1'b1;
                    pslot_next = idx_reg;
                    psubs_next = rd_count;
                    pper_next  = rd_per;
                    dl_we      = 1'b1;
                    if (!sum_past)
                    begin
                        state_next = aft_pkg::S_CATCHUP;
                    end
                    else if (last_slot)
                    begin
                        state_next = aft_pkg::S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (last_slot)
                begin
                    state_next = aft_pkg::S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            aft_pkg::S_CATCHUP:
            begin
                // Keep adding the period until the deadline is past now.
                dl_we = 1'b1;
                if (sum_past)
                begin
                    if (last_slot)
                    begin
                        state_next = aft_pkg::S_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = aft_pkg::S_TICK_SCAN;
                    end
                end
            end

            aft_pkg::S_FLUSH:
            begin
                if (pend_reg)
                begin
                    rv_next     = 1'b1;
                    kind_next   = aft_pkg::KIND_FIRE;
                    status_next = aft_pkg::ST_OK;
                    sidx_next   = pslot_reg;
                    subs_next   = psubs_reg;
                    per_next    = pper_reg;
                    last_next   = 1'b1;
                end
                pend_next  = 1'b0;
                state_next = aft_pkg::S_IDLE;
            end

            default:
            begin
                state_next = aft_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aft_pkg::S_IDLE;
            now_reg      <= '0;
            idx_reg      <= '0;
            free_reg     <= '0;
            free_ok_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            result_valid <= 1'b0;
            used_reg     <= '0;
            for (int i = 0; i < aft_pkg::NUM_SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            idx_reg      <= idx_next;
            free_reg     <= free_next;
            free_ok_reg  <= free_ok_next;
            pend_reg     <= pend_next;
            result_valid <= rv_next;
            if (alloc_we)
            begin
                used_reg[wr_idx]  <= 1'b1;
                count_reg[wr_idx] <= CW'(1);
            end
            else if (cnt_we)
            begin
                count_reg[wr_idx] <= cnt_wdata;
                if (used_clr)
                begin
                    used_reg[wr_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers and slot fields.
    always_ff @(posedge clk)
    begin
        kind         <= kind_next;
        status       <= status_next;
        slot_index   <= sidx_next;
        subscribers  <= subs_next;
        period_ticks <= per_next;
        last         <= last_next;
        pslot_reg    <= pslot_next;
        psubs_reg    <= psubs_next;
        pper_reg     <= pper_next;
        if (state_reg == aft_pkg::S_IDLE)
        begin
            rate_reg <= frame_rate;
            chan_reg <= channel_count;
            bits_reg <= sample_bits;
        end
        // Bytes per second: two registered multiplies.
        if (state_reg == aft_pkg::S_MUL_A)
        begin
            prod_a_reg <= aft_pkg::BPS_A_W'(bits_reg[aft_pkg::BITS_W-1:3])
                          * aft_pkg::BPS_A_W'(chan_reg);
            num_reg    <= PW'(chunk_bytes) * PW'(tick_rate);
        end
        if (state_reg == aft_pkg::S_MUL_B)
        begin
            bps_reg <= aft_pkg::BPS_W'(prod_a_reg) * aft_pkg::BPS_W'(rate_reg);
        end
        if (alloc_we)
        begin
            rate_tbl[wr_idx] <= rate_reg;
            chan_tbl[wr_idx] <= chan_reg;
            bits_tbl[wr_idx] <= bits_reg;
            per_tbl[wr_idx]  <= new_per;
            dl_tbl[wr_idx]   <= sum;
        end
        else if (dl_we)
        begin
            dl_tbl[wr_idx] <= sum;
        end
    end

endmodule

@@ design/aft_checker.sv @@
// Port-level checker of the audio format tick scheduler and its bind statement.
// Depends on aft_pkg and audio_format_tick_scheduler_defines.svh.
`include "audio_format_tick_scheduler_defines.svh"

module aft_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pready,
    input logic                          result_valid,
    input logic [1:0]                    kind,
    input logic [2:0]                    status,
    input logic [aft_pkg::PERIOD_W-1:0]  period_ticks,
    input logic                          last
);

    // Error replies carry no period.
    `AFT_ASSERT_IMP(a_err_no_period, result_valid && status != aft_pkg::ST_OK, period_ticks == '0)

    // Register and unregister replies are single results.
    `AFT_ASSERT_IMP(a_reply_last, result_valid && kind != aft_pkg::KIND_FIRE, last)

    // Fired channels always report success.
    `AFT_ASSERT_IMP(a_fire_ok, result_valid && kind == aft_pkg::KIND_FIRE, status == aft_pkg::ST_OK)

    // The configuration port never waits.
    `AFT_ASSERT_NEXT(a_pready, 1'b1, pready)

endmodule

bind audio_format_tick_scheduler aft_checker u_aft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .result_valid (result_valid),
    .kind         (kind),
    .status       (status),
    .period_ticks (period_ticks),
    .last         (last)
);
